// ===== design/netbios_name_query_decoder_unit_macros.svh =====
// Assertion macros used by the NetBIOS name query decoder top level.
`ifndef NETBIOS_NAME_QUERY_DECODER_UNIT_MACROS_SVH
`define NETBIOS_NAME_QUERY_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while in reset.
`define NBNQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while in reset.
`define NBNQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nbnq_pkg.sv =====
// Types and constants of the NetBIOS name query decoder.
package nbnq_pkg;

    // Protocol constants.
    localparam logic [15:0] NB_PORT       = 16'd137;
    localparam logic [5:0]  Q_HIGH_POS    = 6'd4;
    localparam logic [5:0]  Q_LOW_POS     = 6'd5;
    localparam logic [5:0]  HDR_LEN       = 6'd12;
    localparam logic [5:0]  NAME_START    = 6'd13;
    localparam logic [5:0]  END_POS       = 6'd45;
    localparam logic [7:0]  NAME_LEN      = 8'd32;
    localparam logic [3:0]  SUFFIX_PAIR   = 4'd15;
    localparam logic [7:0]  CHAR_BASE     = 8'h41;
    localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_SUFFIX  = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        VERDICT_ACCEPTED     = 3'd0,
        VERDICT_NOT_PORT     = 3'd1,
        VERDICT_SHORT_HEADER = 3'd2,
        VERDICT_NO_QUESTION  = 3'd3,
        VERDICT_BAD_LENGTH   = 3'd4,
        VERDICT_TRUNCATED    = 3'd5
    } verdict_t;

    // One input request: a payload byte with its packet marks and ports.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_of_packet;
        logic        last_of_packet;
        logic        payload_empty;
        logic [15:0] source_port;
        logic [15:0] target_port;
    } item_t;

    // One result: a name character, the suffix, or the packet verdict.
    typedef struct packed {
        kind_t       result_kind;
        logic [3:0]  char_index;
        logic [7:0]  char_value;
        verdict_t    verdict;
        logic [31:0] accepted_total;
        logic        last_result;
    } result_t;

    // Per-packet parse state plus the running accepted count.
    typedef struct packed {
        logic [5:0]  byte_pos;
        logic        port_match;
        logic [7:0]  q_high;
        logic [7:0]  pair_first;
        verdict_t    status;
        logic [31:0] accepted_count;
    } parse_state_t;

    // Which result slots the decoder fills for one request.
    typedef struct packed {
        logic lead;
        logic trail;
    } push_t;

endpackage

// ===== design/nbnq_decode.sv =====
// Combinational decode of one request against the parse state.
module nbnq_decode (
    input  nbnq_pkg::parse_state_t state,
    input  nbnq_pkg::item_t        item,
    output nbnq_pkg::parse_state_t state_next,
    output nbnq_pkg::push_t        push,
    output nbnq_pkg::result_t      lead,
    output nbnq_pkg::result_t      trail
);
    import nbnq_pkg::*;

    parse_state_t st;
    parse_state_t nx;
    logic [5:0]   offset;
    logic [3:0]   pair;
    logic [7:0]   hi_part;
    logic [7:0]   lo_part;
    logic [7:0]   char_val;
    logic         char_emit;
    logic         finish;
    verdict_t     verd;
    logic [31:0]  count_new;
    result_t      char_res;
    result_t      verd_res;

    // Restart the packet state on a first mark or an empty payload.
    always_comb
    begin
        st = state;
        if (item.payload_empty || item.first_of_packet)
        begin
            st.byte_pos   = '0;
            st.port_match = (item.source_port == NB_PORT) || (item.target_port == NB_PORT);
            st.q_high     = '0;
            st.pair_first = '0;
            st.status     = VERDICT_ACCEPTED;
        end
    end

    // Pair decoding: high nibble from the first byte, offset of the second ORed in.
    assign offset   = st.byte_pos - NAME_START;
    assign pair     = offset[4:1];
    assign hi_part  = st.pair_first - CHAR_BASE;
    assign lo_part  = item.data_byte - CHAR_BASE;
    assign char_val = {hi_part[3:0], 4'b0000} | lo_part;

    // Byte position walk through header, length byte and name pairs.
    always_comb
    begin
        nx        = st;
        char_emit = 1'b0;
        if (!item.payload_empty && (st.byte_pos < END_POS))
        begin
            if (st.byte_pos == Q_HIGH_POS)
            begin
                nx.q_high = item.data_byte;
            end
            else if (st.byte_pos == Q_LOW_POS)
            begin
                if (((st.q_high | item.data_byte) == 8'd0) &&
                    (st.status == VERDICT_ACCEPTED))
                begin
                    nx.status = VERDICT_NO_QUESTION;
                end
            end
            else if (st.byte_pos == HDR_LEN)
            begin
                if ((item.data_byte != NAME_LEN) && (st.status == VERDICT_ACCEPTED))
                begin
                    nx.status = VERDICT_BAD_LENGTH;
                end
            end
            else if (st.byte_pos > HDR_LEN)
            begin
                if (!offset[0])
                begin
                    nx.pair_first = item.data_byte;
                end
                else
                begin
                    char_emit = st.port_match && (st.status == VERDICT_ACCEPTED);
                end
            end
            nx.byte_pos = st.byte_pos + 6'd1;
        end
    end

    // Verdict in priority order, taken on the state after this byte.
    always_comb
    begin
        if (!nx.port_match)
        begin
            verd = VERDICT_NOT_PORT;
        end
        else if (nx.byte_pos < HDR_LEN)
        begin
            verd = VERDICT_SHORT_HEADER;
        end
        else if (nx.status != VERDICT_ACCEPTED)
        begin
            verd = nx.status;
        end
        else if (nx.byte_pos < END_POS)
        begin
            verd = VERDICT_TRUNCATED;
        end
        else
        begin
            verd = VERDICT_ACCEPTED;
        end
    end

    assign finish = item.payload_empty || item.last_of_packet;

    // Saturating count of accepted packets.
    always_comb
    begin
        count_new = nx.accepted_count;
        if (finish && (verd == VERDICT_ACCEPTED) && (nx.accepted_count != COUNT_MAX))
        begin
            count_new = nx.accepted_count + 32'd1;
        end
    end

    // Assemble the two possible results.
    always_comb
    begin
        char_res.result_kind    = (pair < SUFFIX_PAIR) ? KIND_CHAR : KIND_SUFFIX;
        char_res.char_index     = (pair < SUFFIX_PAIR) ? pair : 4'd0;
        char_res.char_value     = char_val;
        char_res.verdict        = VERDICT_ACCEPTED;
        char_res.accepted_total = '0;
        char_res.last_result    = 1'b0;

        verd_res.result_kind    = KIND_VERDICT;
        verd_res.char_index     = '0;
        verd_res.char_value     = '0;
        verd_res.verdict        = verd;
        verd_res.accepted_total = count_new;
        verd_res.last_result    = 1'b1;
    end

    // A character always goes first; the verdict follows it or stands alone.
    always_comb
    begin
        state_next                = nx;
        state_next.accepted_count = count_new;
        push.lead                 = char_emit || finish;
        push.trail                = char_emit && finish;
        lead                      = char_emit ? char_res : verd_res;
        trail                     = verd_res;
    end

endmodule

// ===== design/nbnq_result_fifo.sv =====
// Small result queue taking up to two results per cycle and giving one.
module nbnq_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nbnq_pkg::push_t                      push,
    input  nbnq_pkg::result_t                    lead,
    input  nbnq_pkg::result_t                    trail,
    output logic [$clog2(DEPTH + 1) - 1:0]       level,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output nbnq_pkg::result_t                    result
);
    import nbnq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W - 1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    result_t            result_mem_reg [DEPTH];
    logic [PTR_W - 1:0] wr_ptr_reg;
    logic [PTR_W - 1:0] wr_ptr_next;
    logic [PTR_W - 1:0] rd_ptr_reg;
    logic [PTR_W - 1:0] rd_ptr_next;
    logic [LVL_W - 1:0] level_reg;
    logic [LVL_W - 1:0] level_next;
    logic [PTR_W - 1:0] wr_ptr_plus1;
    logic [PTR_W - 1:0] wr_ptr_plus2;
    logic               pop;

    // Pointer wrap for any depth.
    assign wr_ptr_plus1 = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_plus2 = (wr_ptr_plus1 == LAST_SLOT) ? '0 : wr_ptr_plus1 + PTR_W'(1);

    assign pop = result_valid && result_ready;

    // Next pointers and fill level.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.trail)
        begin
            wr_ptr_next = wr_ptr_plus2;
        end
        else if (push.lead)
        begin
            wr_ptr_next = wr_ptr_plus1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        level_next = level_reg + LVL_W'(push.lead) + LVL_W'(push.trail) - LVL_W'(pop);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Result storage; entries need no reset.
    always_ff @(posedge clk)
    begin
        if (push.lead)
        begin
            result_mem_reg[wr_ptr_reg] <= lead;
        end
        if (push.trail)
        begin
            result_mem_reg[wr_ptr_plus1] <= trail;
        end
    end

    assign level        = level_reg;
    assign result_valid = (level_reg != '0);
    assign result       = result_mem_reg[rd_ptr_reg];

endmodule

// ===== design/netbios_name_query_decoder_unit.sv =====
// NetBIOS name query decoder: top level with parse state, result queue and checks.
//
// Takes the UDP payload of a packet one byte per request and decodes the first-level
// encoded NetBIOS name of the first question, giving 15 name characters, the suffix
// and, on the last byte, a verdict with a saturating count of accepted packets.
// A request is taken in every cycle while the result queue has room for two results;
// each byte is decoded in the cycle it is accepted and its results are queued, so the
// first result can be taken in the cycle after its byte. Each result leaves in a cycle of
// its own, so the byte that completes the suffix and also ends the packet gives two
// results that leave one after the other; a sustained stream of such bytes runs at the
// output's one result per cycle while result_ready is held. The queue depth RESULT_DEPTH
// (at least 2) sets how long the input keeps flowing while the output is stalled.
`include "netbios_name_query_decoder_unit_macros.svh"

module netbios_name_query_decoder_unit #(
    parameter int RESULT_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  nbnq_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output nbnq_pkg::result_t result
);
    import nbnq_pkg::*;

    localparam int LVL_W = $clog2(RESULT_DEPTH + 1);
    localparam logic [LVL_W - 1:0] READY_LEVEL = LVL_W'(RESULT_DEPTH - 2);

    parse_state_t       state_reg;
    parse_state_t       state_next;
    parse_state_t       decoded_state;
    push_t              decoded_push;
    push_t              push;
    result_t            lead;
    result_t            trail;
    logic [LVL_W - 1:0] level;
    logic               accept;

    // Input is taken while two result slots are free.
    assign item_ready = (level <= READY_LEVEL);
    assign accept     = item_valid && item_ready;

    nbnq_decode u_decode (
        .state      (state_reg),
        .item       (item),
        .state_next (decoded_state),
        .push       (decoded_push),
        .lead       (lead),
        .trail      (trail)
    );

    // State and queue writes only on an accepted request.
    always_comb
    begin
        state_next = accept ? decoded_state : state_reg;
        push.lead  = accept && decoded_push.lead;
        push.trail = accept && decoded_push.trail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    nbnq_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .lead         (lead),
        .trail        (trail),
        .level        (level),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Checks on queue occupancy, byte position, the last result's kind and the accepted count.
    `NBNQ_ASSERT_NOW(a_level_bound, 1'b1, level <= LVL_W'(RESULT_DEPTH), "result queue overflow")
    `NBNQ_ASSERT_NOW(a_pos_bound, 1'b1, state_reg.byte_pos <= END_POS, "byte position past end")
    `NBNQ_ASSERT_NOW(a_last_is_verdict, result_valid && result.last_result, result.result_kind == KIND_VERDICT, "last result is not a verdict")
    `NBNQ_ASSERT_NEXT(a_count_monotonic, 1'b1, state_reg.accepted_count >= $past(state_reg.accepted_count), "accepted count decreased")

endmodule
